/* src/stepper_step_time_planner_assert.svh */
// Assertion macros used by the step time planner controller.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef STEPPER_STEP_TIME_PLANNER_ASSERT_SVH
`define STEPPER_STEP_TIME_PLANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSTP_ASSERT_IMP(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSTP_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`endif

/* src/sstp_pkg.sv */
// Package for the step time planner: constants, controller states,
// datapath commands and status. No dependencies.
package sstp_pkg;

	localparam int FRAC_W = 16;
	localparam logic [15:0] PERIOD_TICKS = 16'hFFFF;
	localparam logic [6:0] MAX_STEPS = 7'd64;
	localparam logic [40:0] DSCALE_MAX = 41'h100_0000_0000;

	localparam logic REG_VSCALE = 1'b0;
	localparam logic REG_DSCALE = 1'b1;

	localparam logic [1:0] PWR_HOLD = 2'd0;
	localparam logic [1:0] PWR_RUN  = 2'd1;
	localparam logic [1:0] PWR_ACC  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_VMUL, ST_PREP, ST_FHI, ST_INIT, ST_CHK0, ST_STEP,
		ST_TA, ST_TB, ST_TC, ST_TD, ST_TE, ST_LOOP, ST_EMIT, ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_MUL_V, OP_PREP, OP_MUL_FH, OP_INIT_S, OP_STEP,
		OP_TR_A, OP_TR_B, OP_TR_C, OP_TR_D, OP_TR_E, OP_MID, OP_RESULT,
		OP_LOAD_OUT, OP_FINISH
	} dp_op_t;

	typedef enum logic [1:0] {
		PH_LO, PH_HI, PH_MID
	} phase_t;

	typedef struct packed {
		dp_op_t op;
		phase_t phase;
		logic   last;
	} dp_cmd_t;

	typedef struct packed {
		logic [6:0] n;
		logic       cont;
	} dp_status_t;

endpackage

/* src/sstp_in_if.sv */
// Input channel of the step time planner: one motion period per item.
// Depends on nothing.
interface sstp_in_if;
	logic               valid;
	logic               ready;
	logic               load_acceleration;
	logic signed [23:0] new_acceleration;

	modport source (output valid, load_acceleration, new_acceleration, input ready);
	modport sink (input valid, load_acceleration, new_acceleration, output ready);
endinterface

/* src/sstp_out_if.sv */
// Output channel of the step time planner: one step event per item.
// Depends on nothing.
interface sstp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] step_time;
	logic        step_direction;
	logic [1:0]  power_level;
	logic        last_step;

	modport source (output valid, step_time, step_direction, power_level, last_step,
		input ready);
	modport sink (input valid, step_time, step_direction, power_level, last_step,
		output ready);
endinterface

/* src/stepper_step_time_planner.sv */
// Step time planner for one stepper motor with constant acceleration. Each
// input item is one motion period; it may load a new acceleration, and the
// block then emits one item per step of that period (time tick, direction,
// power level, last marker), at most 64, before it takes the next period.
// An item runs through the setup states, then per emitted step a bisection
// search over the 16-bit step time, and a closing state; a period without
// steps goes from setup straight to the closing state. A step item that
// cannot leave because the previous one still waits in the output register
// holds the sequence until the receiver takes it. The pace is set by
// the one shared multiplier: each distance evaluation along the bisection
// runs through it in three passes and a final add and compare. The last
// result of a period may still wait in the output register while the next
// period is accepted. A register write takes effect at any cycle, so the
// registers must be written only while the block is idle with no period
// in work.
module stepper_step_time_planner
	import sstp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [40:0] cfg_wdata,
	sstp_in_if.sink     plan_in,
	sstp_out_if.source  step_out
);

	// Command and status between the sequencer and the arithmetic.
	dp_cmd_t    cmd;
	dp_status_t st;

	sstp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (plan_in.valid),
		.in_ready  (plan_in.ready),
		.out_ready (step_out.ready),
		.out_valid (step_out.valid),
		.cmd       (cmd),
		.st        (st)
	);

	sstp_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.load_acceleration (plan_in.load_acceleration),
		.new_acceleration  (plan_in.new_acceleration),
		.cmd               (cmd),
		.st                (st),
		.step_time         (step_out.step_time),
		.step_direction    (step_out.step_direction),
		.power_level       (step_out.power_level),
		.last_step         (step_out.last_step)
	);

endmodule

/* src/sstp_dp.sv */
// Datapath of the step time planner: motion state, configuration, one shared
// multiplier, bisection bounds and the output register. Uses sstp_pkg.
module sstp_dp
	import sstp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [40:0]        cfg_wdata,
	input  logic               load_acceleration,
	input  logic signed [23:0] new_acceleration,
	input  dp_cmd_t            cmd,
	output dp_status_t         st,
	output logic [15:0]        step_time,
	output logic               step_direction,
	output logic [1:0]         power_level,
	output logic               last_step
);

	logic signed [23:0] acc_q;
	logic signed [31:0] vel_q;
	logic [15:0]        frac_q;
	logic [31:0]        pos_q;
	logic [20:0]        vscale_q;
	logic [40:0]        dscale_q;

	logic signed [18:0] steps_q;
	logic [15:0]        rem_q;
	logic [6:0]         n_q;
	logic               back_q;
	logic [1:0]         power_q;

	logic signed [32:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [54:0] prod_q;
	logic signed [53:0] vp_q;
	logic signed [53:0] x_q;
	logic [43:0]        plo_q;
	logic [36:0]        flo_q;
	logic signed [63:0] s_q;
	logic [15:0]        tt_q, lo_q, hi_q, tcur_q;
	logic               ge_lo_q, mode_q;

	logic signed [34:0] sum;
	logic signed [18:0] steps;
	logic [19:0]        mag;
	logic [56:0]        unit;
	logic [56:0]        fd;
	logic signed [71:0] trav;
	logic signed [71:0] s_ext;
	logic [16:0]        mid_sum;

	assign sum = {{11{acc_q[23]}}, acc_q} + {{2{vel_q[31]}}, vel_q, 1'b0}
		+ {19'b0, frac_q};
	assign steps = sum[34:16];
	assign mag = steps[18] ? (20'd0 - {steps[18], steps}) : {steps[18], steps};
	assign unit = {dscale_q, 16'b0};
	assign fd = {prod_q[35:0], 21'b0} + {20'b0, flo_q};
	assign trav = {prod_q[43], prod_q[43:0], 27'b0} + {28'b0, plo_q};
	assign s_ext = {{8{s_q[63]}}, s_q};
	assign mid_sum = {1'b0, hi_q} + {1'b0, lo_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_V: begin
				mul_a = {vel_q[31], vel_q};
				mul_b = {1'b0, vscale_q};
			end
			OP_PREP: begin
				mul_a = {12'b0, dscale_q[20:0]};
				mul_b = {6'b0, frac_q};
			end
			OP_MUL_FH: begin
				mul_a = {13'b0, dscale_q[40:21]};
				mul_b = {6'b0, frac_q};
			end
			OP_TR_A: begin
				mul_a = {{9{acc_q[23]}}, acc_q};
				mul_b = {6'b0, tt_q};
			end
			OP_TR_C: begin
				mul_a = {6'b0, x_q[26:0]};
				mul_b = {6'b0, tt_q};
			end
			OP_TR_D: begin
				mul_a = {{6{x_q[53]}}, x_q[53:27]};
				mul_b = {6'b0, tt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			vel_q    <= '0;
			frac_q   <= '0;
			pos_q    <= '0;
			vscale_q <= 21'd1;
			dscale_q <= 41'd1;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_VSCALE) begin
					vscale_q <= cfg_wdata[20:0];
				end else begin
					dscale_q <= (cfg_wdata > DSCALE_MAX) ? DSCALE_MAX : cfg_wdata;
				end
			end
			if (cmd.op == OP_LOAD && load_acceleration) begin
				acc_q <= new_acceleration;
			end
			if (cmd.op == OP_FINISH) begin
				vel_q  <= vel_q + {{8{acc_q[23]}}, acc_q};
				frac_q <= rem_q;
				pos_q  <= pos_q + {{13{steps_q[18]}}, steps_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 55'(mul_a) * 55'(mul_b);
		case (cmd.op)
			OP_PREP: begin
				vp_q    <= prod_q[53:0];
				steps_q <= steps;
				rem_q   <= sum[15:0];
				back_q  <= steps[18];
				n_q     <= (mag > 20'(MAX_STEPS)) ? MAX_STEPS : mag[6:0];
				power_q <= (acc_q != 0) ? PWR_ACC : ((vel_q == 0) ? PWR_HOLD : PWR_RUN);
			end
			OP_MUL_FH: flo_q <= prod_q[36:0];
			OP_INIT_S: begin
				s_q    <= back_q ? (64'(unit) - 64'(fd)) : (64'd0 - 64'(fd));
				tcur_q <= '0;
			end
			OP_STEP: begin
				s_q  <= back_q ? (s_q - 64'(unit)) : (s_q + 64'(unit));
				lo_q <= tcur_q;
				hi_q <= PERIOD_TICKS;
				tt_q <= tcur_q;
			end
			OP_TR_B: x_q <= prod_q[53:0] + vp_q;
			OP_TR_D: plo_q <= prod_q[43:0];
			OP_TR_E: begin
				case (cmd.phase)
					PH_LO: begin
						ge_lo_q <= s_ext >= trav;
						tt_q    <= PERIOD_TICKS;
					end
					PH_HI: mode_q <= ge_lo_q && (s_ext <= trav);
					default: begin
						if (mode_q ? (s_ext < trav) : (s_ext > trav)) begin
							hi_q <= tt_q;
						end else begin
							lo_q <= tt_q;
						end
					end
				endcase
			end
			OP_MID: tt_q <= mid_sum[16:1];
			OP_RESULT: tcur_q <= mid_sum[16:1];
			OP_LOAD_OUT: begin
				step_time      <= tcur_q;
				step_direction <= back_q;
				power_level    <= power_q;
				last_step      <= cmd.last;
			end
			default: ;
		endcase
	end

	assign st.n = n_q;
	assign st.cont = mode_q ? ({1'b0, lo_q} + 17'd2 < {1'b0, hi_q})
		: ({1'b0, lo_q} + 17'd1 < {1'b0, hi_q});

endmodule

/* src/sstp_ctrl.sv */
// Controller of the step time planner: sequences the datapath through the
// period setup, the bisection per step and the output handshake. Uses sstp_pkg.
`include "stepper_step_time_planner_assert.svh"

module sstp_ctrl
	import sstp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	output dp_cmd_t    cmd,
	input  dp_status_t st
);

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [6:0] k_q, k_d;
	logic       ovalid_q, ovalid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_LO;
			k_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			k_q      <= k_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		k_d       = k_q;
		cmd.op    = OP_NONE;
		cmd.phase = phase_q;
		cmd.last  = (k_q + 7'd1 == st.n);
		in_ready  = 1'b0;
		ovalid_d  = ovalid_q && !out_ready;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				k_d = '0;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = ST_VMUL;
				end
			end
			ST_VMUL: begin
				cmd.op = OP_MUL_V;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.op = OP_PREP;
				state_d = ST_FHI;
			end
			ST_FHI: begin
				cmd.op = OP_MUL_FH;
				state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.op = OP_INIT_S;
				state_d = ST_CHK0;
			end
			ST_CHK0: state_d = (st.n == '0) ? ST_FIN : ST_STEP;
			ST_STEP: begin
				cmd.op = OP_STEP;
				phase_d = PH_LO;
				state_d = ST_TA;
			end
			ST_TA: begin
				cmd.op = OP_TR_A;
				state_d = ST_TB;
			end
			ST_TB: begin
				cmd.op = OP_TR_B;
				state_d = ST_TC;
			end
			ST_TC: begin
				cmd.op = OP_TR_C;
				state_d = ST_TD;
			end
			ST_TD: begin
				cmd.op = OP_TR_D;
				state_d = ST_TE;
			end
			ST_TE: begin
				cmd.op = OP_TR_E;
				if (phase_q == PH_LO) begin
					phase_d = PH_HI;
					state_d = ST_TA;
				end else begin
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (st.cont) begin
					cmd.op = OP_MID;
					phase_d = PH_MID;
					state_d = ST_TA;
				end else begin
					cmd.op = OP_RESULT;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!ovalid_q || out_ready) begin
					cmd.op = OP_LOAD_OUT;
					ovalid_d = 1'b1;
					k_d = k_q + 7'd1;
					state_d = cmd.last ? ST_FIN : ST_STEP;
				end
			end
			ST_FIN: begin
				cmd.op = OP_FINISH;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = ovalid_q;

	`SSTP_ASSERT_IMP(a_out_slot_free, cmd.op == OP_LOAD_OUT, !ovalid_q || out_ready, "result overwritten before it was taken")
	`SSTP_ASSERT_IMP(a_count_bound, state_q == ST_EMIT, k_q < st.n, "step count ran past the period total")
	`SSTP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second item taken while a period is in work")

endmodule
